// ===== sv/rdiv_pkg.sv =====
// Shared types and constants for the restoring divider.
// No dependencies; used by rdiv_ctrl, rdiv_datapath and restoring_divider.
package rdiv_pkg;

   // Fixed port widths
   localparam int OPERAND_W = 16;
   localparam int ACTIVE_W  = 5;

   // Reset value of the operand width register
   localparam logic [ACTIVE_W-1:0] ACTIVE_BITS_RESET = 5'd16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
   } rdiv_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic divisor_zero;
      logic last_step;
   } rdiv_status_type;

endpackage

// ===== sv/restoring_divider.sv =====
// Top level of the unsigned restoring divider.
// Instantiates rdiv_ctrl and rdiv_datapath; depends on rdiv_pkg.
//
// Unsigned restoring divider, one quotient bit per clock. An item is taken
// when start is high and busy is low; dividend and divisor are cut to n bits,
// where n is csr_write_data as last written (reset 16), with 0 read as 1 and
// values above MAX_BITS read as MAX_BITS. The result shows on the rsp_ ports
// for one cycle, marked by rsp_strobe, once the shift-and-subtract loop has
// produced all n quotient bits, one step per cycle through a single
// subtractor. A zero divisor skips the loop and reports in the next cycle,
// with rsp_divide_by_zero set, an all-ones n-bit quotient and the cut
// dividend as remainder; busy then never rises. Otherwise busy falls in the
// strobe cycle, so the next item can be taken at the edge that ends it. The
// receiver cannot stall the block; it must capture the result while
// rsp_strobe is high. Write the width register only while idle.
module restoring_divider #(
   parameter int MAX_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rdiv_pkg::OPERAND_W-1:0] req_dividend,
   input  logic [rdiv_pkg::OPERAND_W-1:0] req_divisor,
   output logic                           rsp_strobe,
   output logic [rdiv_pkg::OPERAND_W-1:0] rsp_quotient,
   output logic [rdiv_pkg::OPERAND_W-1:0] rsp_remainder,
   output logic                           rsp_divide_by_zero,
   input  logic                           csr_write_enable,
   input  logic [rdiv_pkg::ACTIVE_W-1:0]  csr_write_data
);
   import rdiv_pkg::*;

   rdiv_cmd_type    cmd;
   rdiv_status_type status;

   // Sequence the load and the bit steps
   rdiv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Hold operands and run the shift-and-subtract steps
   rdiv_datapath #(
      .MAX_BITS (MAX_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ===== sv/rdiv_ctrl.sv =====
// Controller state machine of the restoring divider.
// Depends on rdiv_pkg for the command and status structs.
module rdiv_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  rdiv_pkg::rdiv_status_type status,
   output rdiv_pkg::rdiv_cmd_type    cmd,
   output logic                     busy,
   output logic                     rsp_strobe
);
   import rdiv_pkg::*;

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   // Decode next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.divisor_zero) begin
                  strobe_in = 1'b1;
               end else begin
                  state_in = RUN;
               end
            end
         end
         RUN: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               strobe_in = 1'b1;
               state_in  = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == RUN);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== sv/rdiv_datapath.sv =====
// Datapath of the restoring divider: width register, operand registers,
// partial remainder, quotient shifter and step counter. Depends on rdiv_pkg.
module rdiv_datapath #(
   parameter int MAX_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rdiv_pkg::rdiv_cmd_type               cmd,
   output rdiv_pkg::rdiv_status_type            status,
   input  logic                                csr_write_enable,
   input  logic [rdiv_pkg::ACTIVE_W-1:0]       csr_write_data,
   input  logic [rdiv_pkg::OPERAND_W-1:0]      req_dividend,
   input  logic [rdiv_pkg::OPERAND_W-1:0]      req_divisor,
   output logic [rdiv_pkg::OPERAND_W-1:0]      rsp_quotient,
   output logic [rdiv_pkg::OPERAND_W-1:0]      rsp_remainder,
   output logic                                rsp_divide_by_zero
);
   import rdiv_pkg::*;

   localparam int W     = MAX_BITS;
   localparam int CNT_W = $clog2(MAX_BITS + 1);

   logic [ACTIVE_W-1:0] active_bits_ff;
   logic [ACTIVE_W:0]   width_wide;
   logic [CNT_W-1:0]    width;
   logic [W-1:0]        mask;
   logic [W-1:0]        dvd_masked;
   logic [W-1:0]        dvs_masked;

   logic [W:0]          rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        dvd_ff, dvd_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                dz_ff, dz_in;

   logic [W:0]          shifted;
   logic [W+1:0]        diff;

   // Hold the operand width register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_bits_ff <= ACTIVE_BITS_RESET;
      end else if (csr_write_enable) begin
         active_bits_ff <= csr_write_data;
      end
   end

   // Clamp the width to 1..MAX_BITS and build the operand mask
   always_comb begin
      if (active_bits_ff == '0) begin
         width_wide = (ACTIVE_W + 1)'(1);
      end else if ({1'b0, active_bits_ff} > (ACTIVE_W + 1)'(MAX_BITS)) begin
         width_wide = (ACTIVE_W + 1)'(MAX_BITS);
      end else begin
         width_wide = {1'b0, active_bits_ff};
      end
      width      = CNT_W'(width_wide);
      mask       = ~({W{1'b1}} << width);
      dvd_masked = W'(req_dividend) & mask;
      dvs_masked = W'(req_divisor) & mask;
   end

   // Trial subtraction of one restoring step
   assign shifted = {rem_ff[W-1:0], dvd_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   // Load operands or advance one quotient bit
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      dz_in    = dz_ff;
      if (cmd.load) begin
         dvs_in   = dvs_masked;
         dvd_in   = dvd_masked << (CNT_W'(W) - width);
         count_in = width;
         if (dvs_masked == '0) begin
            dz_in  = 1'b1;
            rem_in = {1'b0, dvd_masked};
            quo_in = mask;
         end else begin
            dz_in  = 1'b0;
            rem_in = '0;
            quo_in = '0;
         end
      end else if (cmd.step) begin
         dvd_in   = dvd_ff << 1;
         count_in = count_ff - CNT_W'(1);
         if (diff[W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
      end
   end

   // Hold the working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dz_ff    <= 1'b0;
         rem_ff   <= '0;
         quo_ff   <= '0;
         dvd_ff   <= '0;
         dvs_ff   <= '0;
      end else begin
         count_ff <= count_in;
         dz_ff    <= dz_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         dvd_ff   <= dvd_in;
         dvs_ff   <= dvs_in;
      end
   end

   assign status.divisor_zero = (dvs_masked == '0);
   assign status.last_step    = (count_ff == CNT_W'(1));

   assign rsp_quotient       = OPERAND_W'(quo_ff);
   assign rsp_remainder      = OPERAND_W'(rem_ff);
   assign rsp_divide_by_zero = dz_ff;

endmodule
